// ----- rtl/largest_at_most_take_top_defines.svh -----
// assertion macros used by the checker file of largest_at_most_take_top
`ifndef LARGEST_AT_MOST_TAKE_TOP_DEFINES_SVH
`define LARGEST_AT_MOST_TAKE_TOP_DEFINES_SVH

// same-cycle implication, off while reset is high
`define LAMT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define LAMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers the reset cycles
`define LAMT_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lamt_pkg.sv -----
// shared constants and types of the sorted price store
package lamt_pkg;

   localparam int CAPACITY = 1024;
   localparam int PRICE_W  = 30;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_TAKEN    = 2'd2;
   localparam logic [1:0] ST_NONE     = 2'd3;

   typedef struct packed {
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [PRICE_W-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         status;
      logic [PRICE_W-1:0] price;
   } result_type;

endpackage

// ----- rtl/lamt_store.sv -----
// price memory: one write port, one read port with registered read data
module lamt_store (
   input  logic                        clock,
   input  lamt_pkg::mem_req_type       mem_req,
   output logic [lamt_pkg::PRICE_W-1:0] rd_data
);
   import lamt_pkg::*;

   logic [PRICE_W-1:0] price_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         price_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data <= price_mem[mem_req.rd_addr];
      end
   end

endmodule

// ----- rtl/lamt_ctrl.sv -----
// sequencer: binary search over the sorted store, then shift to insert or remove
module lamt_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_action,
   input  logic [lamt_pkg::PRICE_W-1:0] req_amount,
   output logic                         idle,
   output lamt_pkg::mem_req_type        mem_req,
   input  logic [lamt_pkg::PRICE_W-1:0] rd_data,
   output lamt_pkg::result_type         result,
   input  logic                         result_free
);
   import lamt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_WAIT   = 3'd2;
   localparam logic [2:0] S_SH_RD  = 3'd3;
   localparam logic [2:0] S_SH_WR  = 3'd4;
   localparam logic [2:0] S_DL_RD  = 3'd5;
   localparam logic [2:0] S_DL_WR  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]         state_ff,  state_in;
   logic [COUNT_W-1:0] count_ff,  count_in;
   logic               action_ff, action_in;
   logic [PRICE_W-1:0] amount_ff, amount_in;
   logic [COUNT_W-1:0] lo_ff,     lo_in;
   logic [COUNT_W-1:0] hi_ff,     hi_in;
   logic [COUNT_W-1:0] mid_ff,    mid_in;
   logic [COUNT_W-1:0] idx_ff,    idx_in;
   logic [PRICE_W-1:0] best_ff,   best_in;
   logic [1:0]         status_ff, status_in;
   logic [PRICE_W-1:0] price_ff,  price_in;

   logic [COUNT_W-1:0] mid;
   logic [COUNT_W-1:0] idx_dec;
   logic [COUNT_W-1:0] idx_inc;

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_dec = idx_ff - COUNT_W'(1);
   assign idx_inc = idx_ff + COUNT_W'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      action_in = action_ff;
      amount_in = amount_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      idx_in    = idx_ff;
      best_in   = best_ff;
      status_in = status_ff;
      price_in  = price_ff;
      mem_req   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               action_in = req_action;
               amount_in = req_amount;
               lo_in     = '0;
               hi_in     = count_ff;
               if (req_action == ACT_LOAD && count_ff == COUNT_W'(CAPACITY)) begin
                  status_in = ST_FULL;
                  price_in  = '0;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = mid[ADDR_W-1:0];
               mid_in          = mid;
               state_in        = S_WAIT;
            end else if (action_ff == ACT_LOAD) begin
               idx_in   = count_ff;
               state_in = S_SH_RD;
            end else if (lo_ff == '0) begin
               status_in = ST_NONE;
               price_in  = '0;
               state_in  = S_DONE;
            end else begin
               // lo is the upper-bound position, the taken slot sits just below it
               idx_in   = lo_ff - COUNT_W'(1);
               state_in = S_DL_RD;
            end
         end
         S_WAIT: begin
            if (rd_data <= amount_ff) begin
               lo_in   = mid_ff + COUNT_W'(1);
               best_in = rd_data;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SEARCH;
         end
         S_SH_RD: begin
            if (idx_ff != lo_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_dec[ADDR_W-1:0];
               state_in        = S_SH_WR;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = lo_ff[ADDR_W-1:0];
               mem_req.wr_data = amount_ff;
               count_in        = count_ff + COUNT_W'(1);
               status_in       = ST_INSERTED;
               price_in        = '0;
               state_in        = S_DONE;
            end
         end
         S_SH_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff[ADDR_W-1:0];
            mem_req.wr_data = rd_data;
            idx_in          = idx_dec;
            state_in        = S_SH_RD;
         end
         S_DL_RD: begin
            if (idx_inc < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_inc[ADDR_W-1:0];
               state_in        = S_DL_WR;
            end else begin
               count_in  = count_ff - COUNT_W'(1);
               status_in = ST_TAKEN;
               price_in  = best_ff;
               state_in  = S_DONE;
            end
         end
         S_DL_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff[ADDR_W-1:0];
            mem_req.wr_data = rd_data;
            idx_in          = idx_inc;
            state_in        = S_DL_RD;
         end
         S_DONE: begin
            if (result_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      amount_ff <= amount_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      idx_ff    <= idx_in;
      best_ff   <= best_in;
      status_ff <= status_in;
      price_ff  <= price_in;
   end

   assign idle          = (state_ff == S_IDLE);
   assign result.valid  = (state_ff == S_DONE);
   assign result.status = status_ff;
   assign result.price  = price_ff;

endmodule

// ----- rtl/largest_at_most_take_top.sv -----
// top level of the sorted price store with largest-at-most take
// Holds up to 1024 prices sorted ascending in one single-port-read memory. A load transaction
// inserts its price (status 1 when the store is full); a query transaction removes and returns
// the largest price not above its limit (status 3 when there is none). Every transaction gives
// exactly one result, in order. One transaction is processed at a time: the binary search makes
// at most p = floor(log2(n)) + 1 probes for n stored prices, each one memory read and a compare,
// then the m entries above the found slot move by one place, each with one memory read and one
// write back.
// A finished result waits in an output register while the next transaction is taken. No
// clearing pass runs after reset; the store is usable in the cycle after reset drops.
module largest_at_most_take_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic [lamt_pkg::PRICE_W-1:0] req_amount,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [lamt_pkg::PRICE_W-1:0] rsp_price_taken
);
   import lamt_pkg::*;

   mem_req_type        mem_req;
   logic [PRICE_W-1:0] rd_data;
   result_type         result;
   logic               idle;
   logic               result_free;

   logic               rsp_valid_ff,  rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [PRICE_W-1:0] rsp_price_ff,  rsp_price_in;

   lamt_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   lamt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_action  (req_action),
      .req_amount  (req_amount),
      .idle        (idle),
      .mem_req     (mem_req),
      .rd_data     (rd_data),
      .result      (result),
      .result_free (result_free)
   );

   assign req_stall   = !idle;
   // output slot takes a new result when empty or being drained this cycle
   assign result_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_price_in  = rsp_price_ff;
      if (result_free) begin
         rsp_valid_in  = result.valid;
         rsp_status_in = result.status;
         rsp_price_in  = result.price;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_price_ff  <= rsp_price_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_price_taken = rsp_price_ff;

endmodule

// ----- rtl/lamt_chk.sv -----
// port-level checker for largest_at_most_take_top, with its bind
`include "largest_at_most_take_top_defines.svh"

module lamt_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic [lamt_pkg::PRICE_W-1:0] rsp_price_taken
);
   import lamt_pkg::*;

   `LAMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `LAMT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_status) && $stable(rsp_price_taken), "stalled result changed")
   // only a take carries a price
   `LAMT_ASSERT_NOW(a_price_zero, clock, reset, rsp_valid && rsp_status != ST_TAKEN, rsp_price_taken == '0, "price nonzero without a take")
   `LAMT_ASSERT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid, "result valid right after reset")

endmodule

bind largest_at_most_take_top lamt_chk u_lamt_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_price_taken (rsp_price_taken)
);
